### src/smbg_pkg.sv
// ----------------------------------------------------------------------------
// smbg_pkg
// Shared types and constants of the softmax backward gradient block.
// ----------------------------------------------------------------------------
package smbg_pkg;

  localparam int MaxLenDefault = 64;
  localparam int ExpW = 16;
  localparam int GradW = 16;
  localparam int SumW = 22;
  localparam int WsumW = 38;
  // g*S - D fits in 40 bits signed, a*(g*S-D) in 56 bits signed.
  localparam int NumW = 40;
  localparam int ProdW = 56;
  localparam int MagW = 55;
  localparam int S2W = 44;
  localparam int QW = MagW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SQUARE,
    ST_FETCH,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

### src/smbg_if.sv
// ----------------------------------------------------------------------------
// smbg_in_if / smbg_out_if
// Valid/ready channels for input elements and result words.
// ----------------------------------------------------------------------------
interface smbg_in_if;
  logic valid;
  logic ready;
  logic [15:0] exp_value;
  logic signed [15:0] grad_in;
  logic is_last;
  modport source (output valid, exp_value, grad_in, is_last, input ready);
  modport sink (input valid, exp_value, grad_in, is_last, output ready);
endinterface

interface smbg_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] grad_out;
  logic is_last_res;
  logic sum_zero;
  modport source (output valid, grad_out, is_last_res, sum_zero, input ready);
  modport sink (input valid, grad_out, is_last_res, sum_zero, output ready);
endinterface

### src/softmax_backward_gradient_top.sv
// ----------------------------------------------------------------------------
// softmax_backward_gradient_top
// Softmax backward pass: r = a*(g*S - D)/S^2 per stored element.
// ----------------------------------------------------------------------------
// Usage: elements arrive on in_ch, one word per cycle while loading. Each word
// is stored and summed into S (sum of a) and D (sum of a*g). Elements beyond
// MAX_LEN are dropped, but a dropped last word still ends the vector.
// After the last word, in_ch drops ready. The block forms S^2, then for each
// stored element does two multiplies and a restoring divide that yields one
// quotient bit per cycle. Elements are processed one at a time: the next
// element is not fetched until the result of the one before is loaded
// into the out_ch register. With a zero sum the multiplies and the divide
// are skipped. Each result waits in the out_ch register until taken; a
// stalled receiver holds the sequencer before the next result is loaded.
// When the final result is loaded into the out_ch register, the sums clear
// and in_ch becomes ready again.
// If S is zero every result is zero with sum_zero set. Results are rounded to
// nearest, ties away from zero, and saturated to signed Q4.11.
// Reset (rst, synchronous) clears the sums, the count and the sequencer; the
// element store has no reset.
// ----------------------------------------------------------------------------
module softmax_backward_gradient_top #(
  parameter int MAX_LEN = smbg_pkg::MaxLenDefault
) (
  input logic clk,
  input logic rst,
  smbg_in_if.sink in_ch,
  smbg_out_if.source out_ch
);

  localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam int BitW = $clog2(smbg_pkg::QW + 1);

  logic [smbg_pkg::ExpW-1:0] exp_store [MAX_LEN];
  logic signed [smbg_pkg::GradW-1:0] grad_store [MAX_LEN];

  smbg_pkg::state_t state, state_next;
  logic [CntW-1:0] element_count;
  logic [CntW-1:0] emit_idx;
  logic [smbg_pkg::SumW-1:0] exp_sum;
  logic signed [smbg_pkg::WsumW-1:0] weighted_sum;
  logic [smbg_pkg::S2W-1:0] s2;
  logic [smbg_pkg::ExpW-1:0] rd_exp;
  logic signed [smbg_pkg::GradW-1:0] rd_grad;
  logic signed [smbg_pkg::NumW-1:0] num;
  logic neg;
  logic [smbg_pkg::MagW-1:0] dividend;
  logic [smbg_pkg::S2W:0] rem;
  logic [smbg_pkg::QW-1:0] quo;
  logic [BitW-1:0] bit_cnt;
  logic out_valid;
  logic signed [15:0] res_grad;
  logic out_last;
  logic out_zero;

  logic in_fire, out_fire, store_ok, sum_is_zero, last_elem;
  logic signed [smbg_pkg::ProdW-1:0] prod;
  logic [smbg_pkg::ProdW-1:0] mag;
  logic [smbg_pkg::S2W:0] rem_shift;
  logic [smbg_pkg::S2W:0] rem_sub;
  logic signed [15:0] sat;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign store_ok = element_count < CntW'(MAX_LEN);
  assign sum_is_zero = (exp_sum == '0);
  assign last_elem = (emit_idx + CntW'(1) == element_count);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      smbg_pkg::ST_LOAD: if (in_fire && in_ch.is_last) begin
        state_next = smbg_pkg::ST_SQUARE;
      end
      smbg_pkg::ST_SQUARE: state_next = smbg_pkg::ST_FETCH;
      smbg_pkg::ST_FETCH: begin
        if (element_count == '0) begin
          state_next = smbg_pkg::ST_LOAD;
        end else if (sum_is_zero) begin
          state_next = smbg_pkg::ST_EMIT;
        end else begin
          state_next = smbg_pkg::ST_MUL1;
        end
      end
      smbg_pkg::ST_MUL1: state_next = smbg_pkg::ST_MUL2;
      smbg_pkg::ST_MUL2: state_next = smbg_pkg::ST_DIV;
      smbg_pkg::ST_DIV: if (bit_cnt == BitW'(1)) begin
        state_next = smbg_pkg::ST_EMIT;
      end
      smbg_pkg::ST_EMIT: if (!out_valid) begin
        state_next = last_elem ? smbg_pkg::ST_LOAD : smbg_pkg::ST_FETCH;
      end
      default: state_next = smbg_pkg::ST_LOAD;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready = (state == smbg_pkg::ST_LOAD);
  end

  // Datapath arithmetic.
  always_comb begin
    prod = smbg_pkg::ProdW'($signed({1'b0, rd_exp})) * smbg_pkg::ProdW'(num);
    mag = prod[smbg_pkg::ProdW-1] ? smbg_pkg::ProdW'(-prod) : smbg_pkg::ProdW'(prod);
    rem_shift = {rem[smbg_pkg::S2W-1:0], dividend[smbg_pkg::MagW-1]};
    rem_sub = rem_shift - {1'b0, s2};
    if (neg) begin
      sat = (quo > smbg_pkg::QW'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, quo[15:0]}));
    end else begin
      sat = (quo > smbg_pkg::QW'(32767)) ? 16'sd32767 : $signed(quo[15:0]);
    end
  end

  // Element store.
  always_ff @(posedge clk) begin
    if (in_fire && store_ok) begin
      exp_store[element_count[IdxW-1:0]] <= in_ch.exp_value;
      grad_store[element_count[IdxW-1:0]] <= in_ch.grad_in;
    end
    rd_exp <= exp_store[emit_idx[IdxW-1:0]];
    rd_grad <= grad_store[emit_idx[IdxW-1:0]];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      smbg_pkg::ST_SQUARE: s2 <= smbg_pkg::S2W'(exp_sum) * smbg_pkg::S2W'(exp_sum);
      smbg_pkg::ST_MUL1: begin
        num <= smbg_pkg::NumW'(rd_grad) * smbg_pkg::NumW'($signed({1'b0, exp_sum}))
               - smbg_pkg::NumW'(weighted_sum);
      end
      smbg_pkg::ST_MUL2: begin
        neg <= prod[smbg_pkg::ProdW-1];
        // Rounding: add half the divisor before dividing.
        dividend <= smbg_pkg::MagW'(mag + smbg_pkg::ProdW'(s2 >> 1));
        rem <= '0;
        quo <= '0;
        bit_cnt <= BitW'(smbg_pkg::QW);
      end
      smbg_pkg::ST_DIV: begin
        dividend <= {dividend[smbg_pkg::MagW-2:0], 1'b0};
        bit_cnt <= bit_cnt - BitW'(1);
        if (!rem_sub[smbg_pkg::S2W]) begin
          rem <= rem_sub;
          quo <= {quo[smbg_pkg::QW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[smbg_pkg::QW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smbg_pkg::ST_LOAD;
      element_count <= '0;
      exp_sum <= '0;
      weighted_sum <= '0;
      emit_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (in_fire && store_ok) begin
        element_count <= element_count + CntW'(1);
        exp_sum <= exp_sum + smbg_pkg::SumW'(in_ch.exp_value);
        weighted_sum <= weighted_sum
                        + smbg_pkg::WsumW'($signed({1'b0, in_ch.exp_value}))
                          * smbg_pkg::WsumW'(in_ch.grad_in);
      end
      if (state == smbg_pkg::ST_FETCH && element_count == '0) begin
        emit_idx <= '0;
      end
      if (state == smbg_pkg::ST_EMIT && !out_valid) begin
        out_valid <= 1'b1;
        res_grad <= sum_is_zero ? '0 : sat;
        out_last <= last_elem;
        out_zero <= sum_is_zero;
        if (last_elem) begin
          emit_idx <= '0;
          element_count <= '0;
          exp_sum <= '0;
          weighted_sum <= '0;
        end else begin
          emit_idx <= emit_idx + CntW'(1);
        end
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.grad_out = res_grad;
  assign out_ch.is_last_res = out_last;
  assign out_ch.sum_zero = out_zero;

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (state == smbg_pkg::ST_LOAD))
    else $error("input ready outside load");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    element_count <= CntW'(MAX_LEN))
    else $error("element count over capacity");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_zero) |-> (res_grad == '0))
    else $error("zero-sum result not zero");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == smbg_pkg::ST_EMIT && !out_valid && last_elem) |=> (element_count == '0))
    else $error("sums not cleared after vector");

endmodule
